// File: sv/prt_pkg.sv
`timescale 1ns / 1ps
package prt_pkg;

  // request kinds
  localparam logic [1:0] REQ_UPSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_REPLACED = 3'd2;
  localparam logic [2:0] ST_NO_SLOT  = 3'd3;
  localparam logic [2:0] ST_FOUND    = 3'd4;
  localparam logic [2:0] ST_MISSING  = 3'd5;
  localparam logic [2:0] ST_LIST     = 3'd6;
  localparam logic [2:0] ST_TICK     = 3'd7;

  // configuration register indexes
  localparam logic [0:0] CFG_TIMEOUT  = 1'b0;
  localparam logic [0:0] CFG_INTERVAL = 1'b1;

  localparam int KEY_W  = 256;
  localparam int IP_W   = 32;
  localparam int PORT_W = 16;
  localparam int TIME_W = 32;

  // one stored entry
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] reg_time;
    logic [TIME_W-1:0] seen_time;
  } entry_t;

  // one result item
  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        slot;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic [KEY_W-1:0]  key;
    logic [8:0]        active;
    logic [8:0]        expired;
    logic              last;
  } result_t;

  // wrapping time: a - b is positive and exceeds limit
  function automatic logic later_by_more(input logic [TIME_W-1:0] a,
                                         input logic [TIME_W-1:0] b,
                                         input logic [15:0] limit);
    logic [TIME_W-1:0] d;
    d = a - b;
    return !d[TIME_W-1] && (d > {16'd0, limit});
  endfunction

  // wrapping time: a strictly before b
  function automatic logic earlier(input logic [TIME_W-1:0] a,
                                   input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return d[TIME_W-1];
  endfunction

endpackage

// File: sv/prt_store.sv
`timescale 1ns / 1ps
module prt_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [AW-1:0]        rd_addr,
  output prt_pkg::entry_t      rd_data,
  output logic                 rd_valid,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  prt_pkg::entry_t      wr_data,
  input  logic                 set_en,
  input  logic [AW-1:0]        set_addr,
  input  logic                 set_val
);

  prt_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] valid_r;

  // entry memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // valid map, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (set_en) begin
        valid_r[set_addr] <= set_val;
      end
      rd_valid <= valid_r[rd_addr];
    end
  end

endmodule

// File: sv/peer_registry_table.sv
`timescale 1ns / 1ps
// Peer registry table.
// Input channel in_*: one request item (upsert, lookup or one-second tick),
// fields in in_tdata, want_list/touch in in_tuser. Result channel out_*: one or
// more result items per request, out_tlast marks the final one.
// cfg_*: plain write port for the entry timeout (index 0) and sweep interval
// (index 1), to be written only while idle; the block does not enforce this.
// Each request scans all TABLE_DEPTH slots through the entry memory, one slot
// a cycle; each read is registered and evaluated in the cycle after it is
// issued, then one decide and write-back state follows, and a found lookup
// re-reads its entry before its result. An upsert with a list makes a second
// scan, loading a list item whenever the output register is free. One request
// is worked on at a time; in_tready is high only when the engine is idle, so a
// new request is taken only after the last result of the one before.
// Reset clears the valid map, the clock, the sweep time and the entry count
// at once; no clearing pass. A stalled receiver holds the current result in
// the output register and the list scan waits for it.
module peer_registry_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int LIST_MAX    = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type, key_word0..3, peer_ip, peer_port, padded to 376 bits
  input  logic [375:0] in_tdata,
  // want_list, touch
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, slot, entry_ip, entry_port, entry_key_word0..3,
  // active_count, expired_count, padded to 336 bits
  output logic [335:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_wr_en,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int LW = $clog2(LIST_MAX + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_OUT, S_LIST, S_LOUT
  } state_t;

  state_t state_r;
  logic [1:0]   req_r;
  logic [255:0] key_r;
  logic [31:0]  ip_r;
  logic [15:0]  port_r;
  logic         want_r, touch_r;
  logic [15:0]  timeout_r, interval_r;
  logic [31:0]  now_r, sweep_t_r;
  logic [8:0]   total_r, expired_r;
  logic         sweep_r;
  logic [CW-1:0] addr_r;   // issue pointer
  logic          pv_r;     // read in flight
  logic [AW-1:0] paddr_r;  // address of read in flight
  logic          hit_r, free_r, old_r;
  logic [AW-1:0] hit_s_r, free_s_r, old_s_r;
  logic [31:0]   oldest_r;
  logic [LW-1:0] lcnt_r;
  logic [LW-1:0] lmax_r;   // list items this upsert sends
  logic          ldone_r;
  prt_pkg::result_t res_r;
  prt_pkg::result_t res_nxt;
  logic          ov_r;

  prt_pkg::entry_t rd_data, wr_data;
  logic rd_valid, wr_en, set_en, set_val;
  logic [AW-1:0] wr_addr, set_addr, rd_addr;

  logic          key_kept;
  logic [8:0]    total_after, list_others;
  logic [LW-1:0] list_n;

  prt_store #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_store (
    .clk, .rst_n, .rd_addr, .rd_data, .rd_valid,
    .wr_en, .wr_addr, .wr_data, .set_en, .set_addr, .set_val
  );

  assign rd_addr   = addr_r[AW-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {3'd0, res_r.expired, res_r.active, res_r.key, res_r.port,
                       res_r.ip, res_r.slot, res_r.status};

  logic key_eq, list_stall;
  assign key_eq = (rd_data.key == key_r);
  // a list hit needs the output register free
  assign list_stall = (state_r == S_LIST) && pv_r && rd_valid && !key_eq && ov_r;

  // entry count after the upsert and the number of other entries it lists
  assign key_kept    = hit_r || free_r || old_r;
  assign total_after = (!hit_r && free_r) ? total_r + 9'd1 : total_r;
  assign list_others = total_after - {8'd0, key_kept};
  assign list_n      = (list_others > 9'(LIST_MAX)) ? LW'(LIST_MAX) : LW'(list_others);

  // write-back of the decided, touched or expired entry
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = hit_s_r;
    wr_data  = '{key: key_r, ip: ip_r, port: port_r, reg_time: now_r,
                 seen_time: now_r};
    set_en   = 1'b0;
    set_addr = paddr_r;
    set_val  = 1'b0;
    if (state_r == S_SCAN && pv_r && req_r == prt_pkg::REQ_TICK && sweep_r &&
        rd_valid && prt_pkg::later_by_more(now_r, rd_data.seen_time, timeout_r)) begin
      set_en = 1'b1;
    end
    if (state_r == S_SCAN && pv_r && req_r == prt_pkg::REQ_LOOKUP && touch_r &&
        rd_valid && key_eq && !hit_r) begin
      wr_en   = 1'b1;
      wr_addr = paddr_r;
      wr_data = rd_data;
      wr_data.seen_time = now_r;
    end
    if (state_r == S_DECIDE && req_r == prt_pkg::REQ_UPSERT) begin
      if (hit_r) begin
        wr_en = 1'b1;
      end else if (free_r) begin
        wr_en = 1'b1; wr_addr = free_s_r;
        set_en = 1'b1; set_addr = free_s_r; set_val = 1'b1;
      end else if (old_r) begin
        wr_en = 1'b1; wr_addr = old_s_r;
      end
    end
  end

  // result item loaded by the current state
  always_comb begin
    res_nxt = '0;
    res_nxt.active = total_r;
    case (state_r)
      S_DECIDE: begin
        res_nxt.last = 1'b1;
        case (req_r)
          prt_pkg::REQ_UPSERT: begin
            res_nxt.last = !want_r || (list_n == '0);
            res_nxt.active = total_after;
            if (hit_r) begin
              res_nxt.status = prt_pkg::ST_UPDATED; res_nxt.slot = 8'(hit_s_r);
            end else if (free_r) begin
              res_nxt.status = prt_pkg::ST_INSERTED; res_nxt.slot = 8'(free_s_r);
            end else if (old_r) begin
              res_nxt.status = prt_pkg::ST_REPLACED; res_nxt.slot = 8'(old_s_r);
            end else begin
              res_nxt.status = prt_pkg::ST_NO_SLOT;
            end
          end
          prt_pkg::REQ_LOOKUP: begin
            res_nxt.status = hit_r ? prt_pkg::ST_FOUND : prt_pkg::ST_MISSING;
          end
          default: begin
            res_nxt.status  = prt_pkg::ST_TICK;
            res_nxt.expired = expired_r;
          end
        endcase
      end
      S_LOUT: begin
        res_nxt = res_r;
        res_nxt.slot = 8'(addr_r);
        res_nxt.ip = rd_data.ip; res_nxt.port = rd_data.port;
        res_nxt.key = rd_data.key;
      end
      S_LIST: begin
        res_nxt.status = prt_pkg::ST_LIST;
        res_nxt.slot = 8'(paddr_r);
        res_nxt.ip = rd_data.ip; res_nxt.port = rd_data.port;
        res_nxt.key = rd_data.key;
        res_nxt.last = ((lcnt_r + LW'(1)) == lmax_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      timeout_r  <= 16'd300;
      interval_r <= 16'd30;
      now_r      <= '0;
      sweep_t_r  <= '0;
      total_r    <= '0;
      ov_r       <= 1'b0;
      pv_r       <= 1'b0;
      addr_r     <= '0;
    end else begin
      if (ov_r && out_tready) ov_r <= 1'b0;
      if (cfg_wr_en) begin
        case (cfg_index)
          prt_pkg::CFG_TIMEOUT:  timeout_r  <= cfg_wdata;
          prt_pkg::CFG_INTERVAL: interval_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tdata[1:0] != 2'd3) begin
            req_r   <= in_tdata[1:0];
            key_r   <= in_tdata[257:2];
            ip_r    <= in_tdata[289:258];
            port_r  <= in_tdata[305:290];
            want_r  <= in_tuser[0];
            touch_r <= in_tuser[1];
            hit_r <= 1'b0; free_r <= 1'b0; old_r <= 1'b0;
            expired_r <= '0;
            oldest_r  <= now_r;
            addr_r <= '0; pv_r <= 1'b0;
            sweep_r <= 1'b0;
            if (in_tdata[1:0] == prt_pkg::REQ_TICK) begin
              now_r <= now_r + 32'd1;
              if (prt_pkg::later_by_more(now_r + 32'd1, sweep_t_r, interval_r)) begin
                sweep_r   <= 1'b1;
                sweep_t_r <= now_r + 32'd1;
              end
            end
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one read a cycle, evaluate the previous one
          pv_r    <= (addr_r < DEPTH_C);
          paddr_r <= addr_r[AW-1:0];
          if (addr_r < DEPTH_C) addr_r <= addr_r + 1'b1;
          if (pv_r) begin
            if (rd_valid && key_eq && !hit_r) begin
              hit_r <= 1'b1; hit_s_r <= paddr_r;
            end
            if (!rd_valid && !free_r) begin
              free_r <= 1'b1; free_s_r <= paddr_r;
            end
            if (rd_valid && prt_pkg::earlier(rd_data.reg_time, oldest_r)) begin
              old_r <= 1'b1; old_s_r <= paddr_r; oldest_r <= rd_data.reg_time;
            end
            if (set_en) begin
              expired_r <= expired_r + 9'd1;
              total_r   <= total_r - 9'd1;
            end
          end else if (addr_r == DEPTH_C) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_r  <= res_nxt;
          lmax_r <= list_n;
          if (req_r == prt_pkg::REQ_UPSERT) total_r <= total_after;
          // a found lookup re-reads its entry for the fields
          if (req_r == prt_pkg::REQ_LOOKUP && hit_r) begin
            addr_r <= CW'(hit_s_r);
            state_r <= S_LOUT;
            ldone_r <= 1'b0;
          end else begin
            ov_r <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_LOUT: begin
          // let the re-read complete, then load fields
          if (!ldone_r) begin
            ldone_r <= 1'b1;
          end else begin
            res_r <= res_nxt;
            ov_r <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (ov_r && out_tready) begin
            if (res_r.last) begin
              state_r <= S_IDLE;
            end else begin
              addr_r <= '0; pv_r <= 1'b0; lcnt_r <= '0;
              state_r <= S_LIST;
            end
          end
        end
        S_LIST: begin
          if (!list_stall) begin
            pv_r    <= (addr_r < DEPTH_C);
            paddr_r <= addr_r[AW-1:0];
            if (addr_r < DEPTH_C) addr_r <= addr_r + 1'b1;
          end
          if (pv_r && rd_valid && !key_eq) begin
            if (!ov_r) begin
              res_r <= res_nxt;
              ov_r <= 1'b1;
              lcnt_r <= lcnt_r + 1'b1;
              if (res_nxt.last) begin
                state_r <= S_OUT;
              end
            end else begin
              // hold this read: reissue the same address
              addr_r <= {1'b0, paddr_r};
              pv_r   <= 1'b0;
            end
          end else if (!pv_r && addr_r == DEPTH_C) begin
            // list ran out with nothing pending
            if (!ov_r) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // the engine never presents a result while idle
  ap_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ov_r) else $error("result pending while idle");
  ap_total: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= 9'(TABLE_DEPTH)) else $error("entry count overflow");
  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> (ov_r && $stable(res_r))) else $error("result lost");

endmodule

// File: test/peer_registry_table_tb.sv
`timescale 1ns / 1ps
module peer_registry_table_tb;

  localparam int DEPTH    = 256;
  localparam int LIST_LIM = 10;

  typedef struct {
    logic [1:0]   req;
    logic [255:0] key;
    logic [31:0]  ip;
    logic [15:0]  port;
    logic         want_list;
    logic         touch;
  } request_t;

  // directed row: result typed in when fixed is set, none means no result at all
  typedef struct {
    request_t   rq;
    bit         fixed;
    bit         none;
    logic [2:0] st;
    logic [7:0] slot;
    logic [8:0] act;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [375:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [335:0] out_tdata;
  logic         out_tlast;
  logic         cfg_wr_en = 1'b0;
  logic [0:0]   cfg_index = prt_pkg::CFG_TIMEOUT;
  logic [15:0]  cfg_wdata = '0;

  peer_registry_table dut (.*);

  // shadow table state
  logic         sh_valid [DEPTH];
  logic [255:0] sh_key   [DEPTH];
  logic [31:0]  sh_ip    [DEPTH];
  logic [15:0]  sh_port  [DEPTH];
  logic [31:0]  sh_reg   [DEPTH];
  logic [31:0]  sh_seen  [DEPTH];
  logic [31:0]  sh_now = '0;
  logic [31:0]  sh_last_sweep = '0;
  logic [8:0]   sh_total = '0;
  logic [15:0]  sh_timeout = 16'd300;
  logic [15:0]  sh_interval = 16'd30;

  prt_pkg::result_t pending_results [$];
  logic [255:0] seen_keys [$];
  int           fail_count = 0;
  int           burst_left = 0;
  int           rcv_cyc = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit aged_past(logic [31:0] a, logic [31:0] b, logic [15:0] lim);
    logic [31:0] d;
    d = a - b;
    return !d[31] && (d > {16'd0, lim});
  endfunction

  function automatic bit is_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic prt_pkg::result_t make_result(logic [2:0] st, int s, bit with_entry,
                                                   logic [8:0] expired);
    prt_pkg::result_t r;
    int      k;
    r = '0;
    k = (s < 0) ? 0 : s;
    r.status = st;
    r.slot = k[7:0];
    if (with_entry) begin
      r.ip = sh_ip[k];
      r.port = sh_port[k];
      r.key = sh_key[k];
    end
    r.active = sh_total;
    r.expired = expired;
    return r;
  endfunction

  function automatic void store_entry(int s, request_t rq);
    sh_key[s] = rq.key;
    sh_ip[s] = rq.ip;
    sh_port[s] = rq.port;
    sh_reg[s] = sh_now;
    sh_seen[s] = sh_now;
  endfunction

  // update the shadow table and queue the results one request causes
  function automatic void apply_request(request_t rq);
    int          s;
    int          n;
    int          i;
    logic [2:0]  st;
    logic [31:0] oldest;
    logic [8:0]  expired;
    prt_pkg::result_t r;
    s = -1;
    n = 0;
    expired = '0;
    if (rq.req == prt_pkg::REQ_TICK || rq.req == prt_pkg::REQ_UPSERT ||
        rq.req == prt_pkg::REQ_LOOKUP) begin
      for (i = 0; i < DEPTH; i++)
        if (s < 0 && sh_valid[i] && sh_key[i] == rq.key) s = i;
    end
    case (rq.req)
      prt_pkg::REQ_UPSERT: begin
        if (s >= 0) begin
          store_entry(s, rq);
          st = prt_pkg::ST_UPDATED;
        end else begin
          for (i = 0; i < DEPTH; i++)
            if (s < 0 && !sh_valid[i]) s = i;
          if (s >= 0) begin
            store_entry(s, rq);
            sh_valid[s] = 1'b1;
            sh_total++;
            st = prt_pkg::ST_INSERTED;
          end else begin
            oldest = sh_now;
            for (i = 0; i < DEPTH; i++)
              if (sh_valid[i] && is_before(sh_reg[i], oldest)) begin
                s = i;
                oldest = sh_reg[i];
              end
            if (s >= 0) begin
              store_entry(s, rq);
              st = prt_pkg::ST_REPLACED;
            end else begin
              st = prt_pkg::ST_NO_SLOT;
            end
          end
        end
        pending_results.push_back(make_result(st, s, 1'b0, '0));
        n++;
        if (rq.want_list) begin
          for (i = 0; i < DEPTH && n < 1 + LIST_LIM; i++)
            if (sh_valid[i] && sh_key[i] != rq.key) begin
              pending_results.push_back(make_result(prt_pkg::ST_LIST, i, 1'b1, '0));
              n++;
            end
        end
      end
      prt_pkg::REQ_LOOKUP: begin
        if (s >= 0) begin
          if (rq.touch) sh_seen[s] = sh_now;
          pending_results.push_back(make_result(prt_pkg::ST_FOUND, s, 1'b1, '0));
        end else begin
          pending_results.push_back(make_result(prt_pkg::ST_MISSING, -1, 1'b0, '0));
        end
        n++;
      end
      prt_pkg::REQ_TICK: begin
        sh_now++;
        if (aged_past(sh_now, sh_last_sweep, sh_interval)) begin
          for (i = 0; i < DEPTH; i++)
            if (sh_valid[i] && aged_past(sh_now, sh_seen[i], sh_timeout)) begin
              sh_valid[i] = 1'b0;
              sh_total--;
              expired++;
            end
          sh_last_sweep = sh_now;
        end
        pending_results.push_back(make_result(prt_pkg::ST_TICK, -1, 1'b0, expired));
        n++;
      end
      default: ;
    endcase
    if (n > 0) begin
      r = pending_results.pop_back();
      r.last = 1'b1;
      pending_results.push_back(r);
    end
  endfunction

  // drive one item in bursts with random gaps, return at the falling edge after acceptance
  task automatic send_request(request_t rq, bit fixed, bit none, logic [2:0] st,
                              logic [7:0] slot, logic [8:0] act);
    int           gap;
    int           before_n;
    logic [375:0] word;
    prt_pkg::result_t r;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7, 8:    gap = $urandom_range(1, 5);
        default:       gap = $urandom_range(1, 400);
      endcase
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    word = '0;
    word[305:0] = {rq.port, rq.ip, rq.key, rq.req};
    in_tdata <= word;
    in_tuser <= {rq.touch, rq.want_list};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    before_n = pending_results.size();
    apply_request(rq);
    if (fixed) begin
      while (pending_results.size() > before_n) void'(pending_results.pop_back());
      if (!none) begin
        r = '0;
        r.status = st;
        r.slot = slot;
        r.active = act;
        r.last = 1'b1;
        pending_results.push_back(r);
      end
    end
    @(negedge clk);
  endtask

  // write both registers once the block has drained
  task automatic set_config(logic [15:0] tmo, logic [15:0] ivl);
    in_tvalid <= 1'b0;
    burst_left = 0;
    wait (pending_results.size() == 0);
    repeat (600) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= prt_pkg::CFG_TIMEOUT;
    cfg_wdata <= tmo;
    @(negedge clk);
    cfg_index <= prt_pkg::CFG_INTERVAL;
    cfg_wdata <= ivl;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sh_timeout = tmo;
    sh_interval = ivl;
  endtask

  function automatic logic [255:0] fresh_key();
    logic [255:0] k;
    for (int w = 0; w < 8; w++) k[w*32 +: 32] = $urandom;
    return k;
  endfunction

  // random phase, weights in percent; the rest are unknown request kinds
  task automatic run_random(int count, int p_up, int p_look, int p_tick, int p_new);
    request_t rq;
    int       done;
    int       roll;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(0, 99);
      rq.ip = $urandom;
      rq.port = 16'($urandom);
      rq.want_list = ($urandom_range(0, 3) == 0);
      rq.touch = 1'($urandom_range(0, 1));
      if (seen_keys.size() == 0 || $urandom_range(0, 99) < p_new) begin
        rq.key = fresh_key();
        seen_keys.push_back(rq.key);
      end else begin
        rq.key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
      end
      if (roll < p_up) rq.req = prt_pkg::REQ_UPSERT;
      else if (roll < p_up + p_look) rq.req = prt_pkg::REQ_LOOKUP;
      else if (roll < p_up + p_look + p_tick) rq.req = prt_pkg::REQ_TICK;
      else rq.req = 2'd3;
      // lookups of unknown keys stay rare
      if (rq.req == prt_pkg::REQ_LOOKUP && seen_keys.size() > 0 &&
          $urandom_range(0, 3) != 0)
        rq.key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
      send_request(rq, 1'b0, 1'b0, '0, '0, '0);
      if (rq.req != 2'd3) done++;
    end
  endtask

  // receiver stall pattern, cycling through four modes
  always @(negedge clk) begin
    rcv_cyc <= rcv_cyc + 1;
    case ((rcv_cyc / 97) % 4)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= (rcv_cyc % 5 != 0);
    endcase
  end

  function automatic void check_field(string name, logic [255:0] e, logic [255:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0h actual %0h", name, e, a);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    prt_pkg::result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: %0h", out_tdata);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, out_tdata[2:0]);
        check_field("slot", e.slot, out_tdata[10:3]);
        check_field("entry_ip", e.ip, out_tdata[42:11]);
        check_field("entry_port", e.port, out_tdata[58:43]);
        check_field("entry_key_word0", e.key[63:0], out_tdata[122:59]);
        check_field("entry_key_word1", e.key[127:64], out_tdata[186:123]);
        check_field("entry_key_word2", e.key[191:128], out_tdata[250:187]);
        check_field("entry_key_word3", e.key[255:192], out_tdata[314:251]);
        check_field("active_count", e.active, out_tdata[323:315]);
        check_field("expired_count", e.expired, out_tdata[332:324]);
        check_field("last", e.last, out_tlast);
      end
    end
  end

  initial begin
    row_t         rows [13];
    logic [255:0] k_zero;
    logic [255:0] k_ones;
    logic [255:0] k_a;
    logic [255:0] k_b;
    k_zero = '0;
    k_ones = '1;
    k_a = {64{4'h5}};
    k_b = {64{4'hA}};
    for (int i = 0; i < DEPTH; i++) sh_valid[i] = 1'b0;
    // directed rows under reset settings
    rows[0]  = '{'{prt_pkg::REQ_LOOKUP, k_zero, '0, '0, 1'b0, 1'b1},
                 1, 0, prt_pkg::ST_MISSING, 8'd0, 9'd0};
    rows[1]  = '{'{prt_pkg::REQ_TICK, k_ones, '1, '1, 1'b1, 1'b1},
                 1, 0, prt_pkg::ST_TICK, 8'd0, 9'd0};
    rows[2]  = '{'{prt_pkg::REQ_UPSERT, k_zero, '0, '0, 1'b1, 1'b0},
                 1, 0, prt_pkg::ST_INSERTED, 8'd0, 9'd1};
    rows[3]  = '{'{prt_pkg::REQ_UPSERT, k_ones, '1, '1, 1'b1, 1'b1}, 0, 0, '0, '0, '0};
    rows[4]  = '{'{prt_pkg::REQ_UPSERT, k_a, 32'h01020304, 16'h0506, 1'b0, 1'b0},
                 1, 0, prt_pkg::ST_INSERTED, 8'd2, 9'd3};
    rows[5]  = '{'{prt_pkg::REQ_UPSERT, k_ones, 32'h0a000001, 16'd4000, 1'b0, 1'b0},
                 1, 0, prt_pkg::ST_UPDATED, 8'd1, 9'd3};
    rows[6]  = '{'{prt_pkg::REQ_LOOKUP, k_ones, '0, '0, 1'b0, 1'b1}, 0, 0, '0, '0, '0};
    rows[7]  = '{'{prt_pkg::REQ_LOOKUP, k_ones, '0, '0, 1'b1, 1'b0}, 0, 0, '0, '0, '0};
    rows[8]  = '{'{prt_pkg::REQ_LOOKUP, k_b, '0, '0, 1'b0, 1'b0},
                 1, 0, prt_pkg::ST_MISSING, 8'd0, 9'd3};
    rows[9]  = '{'{2'd3, k_ones, '1, '1, 1'b1, 1'b1}, 1, 1, '0, '0, '0};
    rows[10] = '{'{prt_pkg::REQ_UPSERT, k_b, 32'h80000000, 16'h8000, 1'b1, 1'b1},
                 0, 0, '0, '0, '0};
    rows[11] = '{'{prt_pkg::REQ_TICK, k_zero, '0, '0, 1'b0, 1'b0},
                 1, 0, prt_pkg::ST_TICK, 8'd0, 9'd4};
    rows[12] = '{'{prt_pkg::REQ_UPSERT, k_zero, 32'h7fffffff, 16'h7fff, 1'b1, 1'b0},
                 0, 0, '0, '0, '0};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i])
      send_request(rows[i].rq, rows[i].fixed, rows[i].none, rows[i].st, rows[i].slot,
                   rows[i].act);

    // fill the table and push it into replacement, no sweeps
    set_config(16'hFFFF, 16'hFFFF);
    run_random(300, 90, 5, 4, 97);
    // aggressive aging
    set_config(16'd1, 16'd1);
    run_random(40, 45, 25, 28, 60);
    // zero settings: any positive age expires
    set_config(16'd0, 16'd0);
    run_random(40, 50, 20, 28, 70);
    set_config(16'd120, 16'd5);
    run_random(40, 50, 25, 23, 50);

    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (600) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
